### hw/rtl/hstg_pkg.sv
// hstg_pkg: shared constants and types for the hashed speckle texel generator
// no dependencies; used by the top level, the modulo pipeline and the checker
`default_nettype none

package hstg_pkg;

  // swatch geometry and place hashing
  localparam int unsigned SWATCH_TEXELS = 64;
  localparam int unsigned PLACE_PRIME   = 7919;
  localparam logic [31:0] FMIX_C1       = 32'h85EBCA6B;
  localparam logic [31:0] FMIX_C2       = 32'hC2B2AE35;
  localparam logic [7:0]  OPAQUE_ALPHA  = 8'd255;

  // widths: key holds x + y*64 + 255*7919 without wrap
  localparam int unsigned KEY_W  = 21;
  localparam int unsigned ADDR_W = 22;
  localparam int unsigned SPAN_W = 9;
  localparam int unsigned REM_W  = 9;

  // modulo pipeline: hash bits retired per stage, stage count
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = 32 / DIV_BITS;

  // fields that ride along the pipeline next to the hash
  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        grain;
    logic [ADDR_W-1:0] addr;
  } side_t;

endpackage

`default_nettype wire

### hw/rtl/hstg_mod_pipe.sv
// hstg_mod_pipe: pipelined hash modulo span, a few hash bits per stage
// depends on hstg_pkg; load enables come from the top level's pipeline control
`default_nettype none

module hstg_mod_pipe (
  input  wire logic                            clk,
  input  wire logic [hstg_pkg::DIV_STAGES-1:0] ld,
  input  wire logic [31:0]                     hash_i,
  input  wire logic [hstg_pkg::SPAN_W-1:0]     span_i,
  output logic      [hstg_pkg::REM_W-1:0]      rem_o
);
  import hstg_pkg::*;

  // restoring remainder over a group of hash bits, msb first
  function automatic logic [REM_W-1:0] mod_step(
    input logic [REM_W-1:0]    rem,
    input logic [DIV_BITS-1:0] bits,
    input logic [SPAN_W-1:0]   span
  );
    logic [REM_W:0]   t;
    logic [REM_W-1:0] r;
    r = rem;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, span}) begin
        t = t - {1'b0, span};
      end
      r = t[REM_W-1:0];
    end
    return r;
  endfunction

  logic [31:0]       hash_r  [DIV_STAGES];
  logic [SPAN_W-1:0] span_r  [DIV_STAGES];
  logic [REM_W-1:0]  rem_r   [DIV_STAGES];
  logic [31:0]       hash_in [DIV_STAGES];
  logic [SPAN_W-1:0] span_in [DIV_STAGES];
  logic [REM_W-1:0]  rem_in  [DIV_STAGES];
  logic [REM_W-1:0]  rem_nxt [DIV_STAGES];

  // stage inputs: first stage from the hash, the rest from the stage before
  always_comb begin
    hash_in[0] = hash_i;
    span_in[0] = span_i;
    rem_in[0]  = '0;
    for (int j = 1; j < DIV_STAGES; j++) begin
      hash_in[j] = hash_r[j-1];
      span_in[j] = span_r[j-1];
      rem_in[j]  = rem_r[j-1];
    end
    for (int j = 0; j < DIV_STAGES; j++) begin
      rem_nxt[j] = mod_step(rem_in[j], hash_in[j][31 - DIV_BITS * j -: DIV_BITS],
                            span_in[j]);
    end
  end

  // stage registers, payload only
  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (ld[j]) begin
        hash_r[j] <= hash_in[j];
        span_r[j] <= span_in[j];
        rem_r[j]  <= rem_nxt[j];
      end
    end
  end

  assign rem_o = rem_r[DIV_STAGES-1];

endmodule

`default_nettype wire

### hw/rtl/hashed_speckle_texel_generator_top.sv
// the modulo pipeline retires four hash bits per stage over eight stages
// throughput: one word per cycle; stages hold their word under stall and
// empty stages fill, so input is taken while a finished word waits
// the depth is set by the key stage, the fmix32 stages (a register after
// each multiply and the last shift-xor), the modulo and output stages
// reset (rst_n low, synchronous) clears the stage valid bits only
// hashed_speckle_texel_generator_top: key, fmix32, modulo, saturating add
// depends on hstg_pkg and hstg_mod_pipe
`default_nettype none

module hashed_speckle_texel_generator_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [5:0]                in_texel_x,
  input  wire logic [5:0]                in_texel_y,
  input  wire logic [7:0]                in_terrain_index,
  input  wire logic [7:0]                in_base_red,
  input  wire logic [7:0]                in_base_green,
  input  wire logic [7:0]                in_base_blue,
  input  wire logic [7:0]                in_grain_amount,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  output logic [hstg_pkg::ADDR_W-1:0]    out_byte_offset
);
  import hstg_pkg::*;

  localparam int unsigned MIX_STAGES = 4;
  localparam int unsigned OUT_STAGE  = MIX_STAGES + DIV_STAGES;
  localparam int unsigned N_STAGES   = OUT_STAGE + 1;

  // add a signed offset to a channel, clamp to a byte
  function automatic logic [7:0] sat_add(
    input logic [7:0]        base,
    input logic signed [9:0] off
  );
    logic signed [10:0] s;
    s = $signed({3'b000, base}) + $signed({off[9], off});
    if (s < 0) begin
      return 8'd0;
    end else if (s > 11'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  logic [N_STAGES-1:0] v_r;
  logic [N_STAGES-1:0] v_nxt;
  logic [N_STAGES:0]   ld;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    ld[N_STAGES] = !out_stall;
    for (int k = N_STAGES - 1; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
    v_nxt[0] = ld[0] ? in_valid : v_r[0];
    for (int k = 1; k < N_STAGES; k++) begin
      v_nxt[k] = ld[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = v_r[N_STAGES-1];

  // stage 0: place key and atlas address
  logic [KEY_W-1:0]  key_nxt;
  logic [KEY_W-1:0]  key_r;
  side_t             side0_nxt;
  side_t             side_r [OUT_STAGE];

  always_comb begin
    key_nxt = KEY_W'(in_texel_x)
            + KEY_W'(in_texel_y) * KEY_W'(SWATCH_TEXELS)
            + KEY_W'(in_terrain_index) * KEY_W'(PLACE_PRIME);
    side0_nxt.red   = in_base_red;
    side0_nxt.green = in_base_green;
    side0_nxt.blue  = in_base_blue;
    side0_nxt.grain = in_grain_amount;
    side0_nxt.addr  = ADDR_W'((((32'(in_terrain_index) * SWATCH_TEXELS)
                               + 32'(in_texel_y)) * SWATCH_TEXELS
                               + 32'(in_texel_x)) * 32'd4);
  end

  // stages 1..3: fmix32 with a register after each multiply and after the last shift-xor
  logic [31:0] h0;
  logic [31:0] m1_nxt;
  logic [31:0] m1_r;
  logic [31:0] m2_nxt;
  logic [31:0] m2_r;
  logic [31:0] hash_nxt;
  logic [31:0] hash_r;

  always_comb begin
    h0       = {{(32 - KEY_W){1'b0}}, key_r};
    m1_nxt   = (h0 ^ (h0 >> 16)) * FMIX_C1;
    m2_nxt   = (m1_r ^ (m1_r >> 13)) * FMIX_C2;
    hash_nxt = m2_r ^ (m2_r >> 16);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      key_r     <= key_nxt;
      side_r[0] <= side0_nxt;
    end
    if (ld[1]) begin
      m1_r <= m1_nxt;
    end
    if (ld[2]) begin
      m2_r <= m2_nxt;
    end
    if (ld[3]) begin
      hash_r <= hash_nxt;
    end
    for (int k = 1; k < OUT_STAGE; k++) begin
      if (ld[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // stages 4..11: hash modulo (2*grain + 1)
  logic [REM_W-1:0] rem;

  hstg_mod_pipe u_mod (
    .clk    (clk),
    .ld     (ld[OUT_STAGE-1:MIX_STAGES]),
    .hash_i (hash_r),
    .span_i ({side_r[MIX_STAGES-1].grain, 1'b1}),
    .rem_o  (rem)
  );

  // stage 12: signed offset, saturating add, output register
  logic signed [9:0] off;
  logic [7:0]        red_r;
  logic [7:0]        green_r;
  logic [7:0]        blue_r;
  logic [ADDR_W-1:0] addr_r;

  assign off = $signed({1'b0, rem}) - $signed({2'b00, side_r[OUT_STAGE-1].grain});

  always_ff @(posedge clk) begin
    if (ld[OUT_STAGE]) begin
      red_r   <= sat_add(side_r[OUT_STAGE-1].red, off);
      green_r <= sat_add(side_r[OUT_STAGE-1].green, off);
      blue_r  <= sat_add(side_r[OUT_STAGE-1].blue, off);
      addr_r  <= side_r[OUT_STAGE-1].addr;
    end
  end

  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_alpha       = OPAQUE_ALPHA;
  assign out_byte_offset = addr_r;

endmodule

`default_nettype wire

### hw/rtl/hstg_checker.sv
// hstg_checker: port-level checks for the texel generator, bound to the top
// depends on hstg_pkg
`default_nettype none

module hstg_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [7:0]                  out_red,
  input wire logic [7:0]                  out_green,
  input wire logic [7:0]                  out_blue,
  input wire logic [7:0]                  out_alpha,
  input wire logic [hstg_pkg::ADDR_W-1:0] out_byte_offset
);
  import hstg_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  // input only stalls when the output word is held
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side could move");

  // alpha is always opaque
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha == OPAQUE_ALPHA))
    else $error("alpha word not opaque");

  // a stalled output word stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_byte_offset)))
    else $error("stalled output word changed");

endmodule

bind hashed_speckle_texel_generator_top hstg_checker u_hstg_checker (.*);

`default_nettype wire
